// ===== sv/bcr_pkg.sv =====
package bcr_pkg;

    // Field and register widths
    localparam int PERIOD_W   = 20;
    localparam int LOOP_REG_W = 9;
    localparam int BONUS_W    = 16;
    localparam int SNAP_W     = 24;
    localparam int GAIN_W     = 17;
    localparam int STEP_W     = 24;
    localparam int SERVER_W   = 40;
    localparam int PHASE_W    = 16;
    localparam int BEAT_OUT_W = 9;
    localparam int PROD_W     = SNAP_W + GAIN_W;
    localparam int DELTA_W    = PROD_W - 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_BEATS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BONUS_WINDOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_GAIN     = 3'd4;

    // Register reset values
    localparam logic [PERIOD_W-1:0]   RST_BEAT_PERIOD    = 20'd32768;
    localparam logic [LOOP_REG_W-1:0] RST_LOOP_BEATS     = 9'd16;
    localparam logic [BONUS_W-1:0]    RST_BONUS_WINDOW   = 16'd13107;
    localparam logic [SNAP_W-1:0]     RST_SNAP_THRESHOLD = 24'd65536;
    localparam logic [GAIN_W-1:0]     RST_DRIFT_GAIN     = 17'd6554;

    // Input mode codes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_SYNC = 1'b1;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ADD,
        OP_ERR,
        OP_MUL,
        OP_SYNC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_BEAT,
        OP_PH_STEP
    } op_t;

    typedef enum logic [1:0] {
        CNT_NONE,
        CNT_DIV,
        CNT_PHASE
    } cnt_sel_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_ALWAYS,
        JMP_SYNC
    } jmp_t;

    typedef logic [3:0] pc_t;

    typedef struct packed {
        op_t      op;
        cnt_sel_t cnt;
        logic     loop;
        jmp_t     jmp;
        pc_t      target;
        logic     last;
    } ctl_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;   // zero already mapped to one
        logic [BONUS_W-1:0]  bonus;
        logic [SNAP_W-1:0]   snap;
        logic [GAIN_W-1:0]   gain;
    } cfg_t;

    typedef struct packed {
        logic [BEAT_OUT_W-1:0] beat_index;
        logic                  beat_fired;
        logic [PHASE_W-1:0]    beat_phase;
    } res_t;

    // Program addresses
    localparam pc_t S_ENTRY = 4'd0;
    localparam pc_t S_ADD   = 4'd1;
    localparam pc_t S_DIVI  = 4'd2;
    localparam pc_t S_DIVS  = 4'd3;
    localparam pc_t S_BEAT  = 4'd4;
    localparam pc_t S_PHS   = 4'd5;
    localparam pc_t S_DONE  = 4'd6;
    localparam pc_t S_ERR   = 4'd7;
    localparam pc_t S_MUL   = 4'd8;
    localparam pc_t S_SYNC  = 4'd9;

    localparam ctl_t CTL_IDLE = '{OP_NOP, CNT_NONE, 1'b0, JMP_NONE, S_ENTRY, 1'b0};

    // Microcode ROM
    function automatic ctl_t ucode(input pc_t pc);
        ctl_t cw;
        cw = CTL_IDLE;
        case (pc)
            S_ENTRY:
            begin
                cw.jmp    = JMP_SYNC;
                cw.target = S_ERR;
            end
            S_ADD:   cw.op = OP_ADD;
            S_DIVI:
            begin
                cw.op  = OP_DIV_INIT;
                cw.cnt = CNT_DIV;
            end
            S_DIVS:
            begin
                cw.op   = OP_DIV_STEP;
                cw.loop = 1'b1;
            end
            S_BEAT:
            begin
                cw.op  = OP_BEAT;
                cw.cnt = CNT_PHASE;
            end
            S_PHS:
            begin
                cw.op   = OP_PH_STEP;
                cw.loop = 1'b1;
            end
            S_DONE:  cw.last = 1'b1;
            S_ERR:   cw.op = OP_ERR;
            S_MUL:   cw.op = OP_MUL;
            S_SYNC:
            begin
                cw.op     = OP_SYNC;
                cw.jmp    = JMP_ALWAYS;
                cw.target = S_DIVI;
            end
            default: cw.last = 1'b1;
        endcase
        return cw;
    endfunction

endpackage

// ===== sv/bcr_seq.sv =====
module bcr_seq #(
    parameter int TIME_BITS = 40
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          is_sync,
    input  logic          hold,
    output logic          busy,
    output bcr_pkg::ctl_t ctl
);
    import bcr_pkg::*;

    localparam int CW = $clog2(TIME_BITS);

    logic          busy_reg, busy_next;
    pc_t           pc_reg, pc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    ctl_t          cw;

    assign cw = ucode(pc_reg);

    // next state
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = S_ENTRY;
            end
        end
        else if (cw.loop && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        else
        begin
            case (cw.cnt)
                CNT_DIV:   cnt_next = CW'(TIME_BITS - 1);
                CNT_PHASE: cnt_next = CW'(PHASE_W - 1);
                default:   cnt_next = cnt_reg;
            endcase
            if (cw.last)
            begin
                if (!hold)
                    busy_next = 1'b0;
            end
            else if (cw.jmp == JMP_ALWAYS || (cw.jmp == JMP_SYNC && is_sync))
                pc_next = cw.target;
            else
                pc_next = pc_reg + pc_t'(1);
        end
    end

    // outputs
    always_comb
    begin
        busy = busy_reg;
        ctl  = busy_reg ? cw : CTL_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= S_ENTRY;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== sv/bcr_dpath.sv =====
module bcr_dpath #(
    parameter int TIME_BITS      = 40,
    parameter int MAX_LOOP_BEATS = 256,
    parameter int LOOP_CAP       = (MAX_LOOP_BEATS < 511) ? MAX_LOOP_BEATS : 511,
    parameter int LW             = $clog2(LOOP_CAP + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            mode,
    input  logic [bcr_pkg::STEP_W-1:0]      time_step,
    input  logic [bcr_pkg::SERVER_W-1:0]    server_position,
    input  bcr_pkg::cfg_t                   cfg,
    input  logic [LW-1:0]                   loop_len,
    input  bcr_pkg::ctl_t                   ctl,
    output logic                            is_sync,
    output bcr_pkg::res_t                   res
);
    import bcr_pkg::*;

    localparam int TB  = TIME_BITS;
    localparam int XW  = ((TB > SERVER_W) ? TB : SERVER_W) + 2;
    localparam int MW  = $clog2(LOOP_CAP);
    localparam int BW  = MW + 1;
    localparam int BXW = (BW > BEAT_OUT_W) ? BW : BEAT_OUT_W;

    localparam logic signed [XW-1:0] TMAX_X = {{(XW-TB+1){1'b0}}, {(TB-1){1'b1}}};
    localparam logic signed [XW-1:0] TMIN_X = {{(XW-TB+1){1'b1}}, {(TB-1){1'b0}}};

    function automatic logic signed [TB-1:0] sat_t(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] y;
        y = x;
        if (x > TMAX_X)
            y = TMAX_X;
        else if (x < TMIN_X)
            y = TMIN_X;
        return y[TB-1:0];
    endfunction

    // item latches
    logic                   mode_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [SERVER_W-1:0]    server_reg;
    logic                   fired_reg;

    // architectural state
    logic signed [TB-1:0]   song_reg, song_next;
    logic signed [BW-1:0]   cur_beat_reg;
    logic signed [BW-1:0]   fired_beat_reg;
    logic                   fired_valid_reg;

    // work registers
    logic signed [TB-1:0]   srv_reg;
    logic                   snap_reg;
    logic                   up_reg;
    logic [SNAP_W-1:0]      mag_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [TB-1:0]          a_reg;
    logic [PERIOD_W-1:0]    r_reg;
    logic [MW-1:0]          m_reg;
    logic                   neg_reg;
    logic [PHASE_W-1:0]     phase_reg;

    logic signed [XW-1:0]   song_x, step_x, server_x, err_x, mag_x, delta_x;
    logic signed [TB-1:0]   srv_sat;
    logic [TB-1:0]          song_u, song_abs;
    logic [PERIOD_W:0]      p_x, div_rs, div_diff, ph_rs, ph_diff;
    logic                   div_ge, ph_ge;
    logic [MW:0]            ms, loop_x;
    logic signed [BW-1:0]   m_s, beat_new;
    logic                   fire_now;
    logic signed [BXW-1:0]  beat_x;

    always_comb
    begin
        song_x   = {{(XW-TB){song_reg[TB-1]}}, song_reg};
        step_x   = {{(XW-STEP_W){1'b0}}, step_reg};
        server_x = {{(XW-SERVER_W){server_reg[SERVER_W-1]}}, server_reg};
        srv_sat  = sat_t(server_x);
        err_x    = {{(XW-TB){srv_sat[TB-1]}}, srv_sat} - song_x;
        mag_x    = err_x[XW-1] ? -err_x : err_x;
        delta_x  = {{(XW-DELTA_W){1'b0}}, prod_reg[PROD_W-1:16]};

        song_u   = song_reg;
        song_abs = song_reg[TB-1] ? (~song_u + TB'(1)) : song_u;

        // one restoring step of |song_time| / period, remainder of quotient mod loop
        p_x      = {1'b0, cfg.period};
        div_rs   = {r_reg, a_reg[TB-1]};
        div_diff = div_rs - p_x;
        div_ge   = (div_rs >= p_x);
        loop_x   = (MW+1)'(loop_len);
        ms       = {m_reg, div_ge};

        // one step of the phase fraction
        ph_rs    = {r_reg, 1'b0};
        ph_diff  = ph_rs - p_x;
        ph_ge    = (ph_rs >= p_x);

        m_s      = $signed({1'b0, m_reg});
        beat_new = neg_reg ? -m_s : m_s;
        fire_now = (r_reg < PERIOD_W'(cfg.bonus))
                 && (!fired_valid_reg || beat_new != fired_beat_reg);

        song_next = song_reg;
        case (ctl.op)
            OP_ADD:  song_next = sat_t(song_x + step_x);
            OP_SYNC:
            begin
                if (snap_reg)
                    song_next = srv_reg;
                else if (up_reg)
                    song_next = sat_t(song_x + delta_x);
                else
                    song_next = sat_t(song_x - delta_x);
            end
            default: song_next = song_reg;
        endcase
    end

    // state that reset clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            song_reg        <= '0;
            cur_beat_reg    <= '0;
            fired_beat_reg  <= '0;
            fired_valid_reg <= 1'b0;
        end
        else
        begin
            song_reg <= song_next;
            if (ctl.op == OP_BEAT && mode_reg == MODE_TICK)
            begin
                cur_beat_reg <= beat_new;
                if (fire_now)
                begin
                    fired_beat_reg  <= beat_new;
                    fired_valid_reg <= 1'b1;
                end
            end
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg   <= mode;
            step_reg   <= time_step;
            server_reg <= server_position;
            fired_reg  <= 1'b0;
        end
        case (ctl.op)
            OP_ERR:
            begin
                srv_reg  <= srv_sat;
                up_reg   <= ~err_x[XW-1];
                snap_reg <= (mag_x > {{(XW-SNAP_W){1'b0}}, cfg.snap});
                mag_reg  <= mag_x[SNAP_W-1:0];
            end
            OP_MUL:  prod_reg <= mag_reg * cfg.gain;
            OP_DIV_INIT:
            begin
                a_reg   <= song_abs;
                r_reg   <= '0;
                m_reg   <= '0;
                neg_reg <= song_reg[TB-1];
            end
            OP_DIV_STEP:
            begin
                a_reg <= {a_reg[TB-2:0], 1'b0};
                r_reg <= div_ge ? div_diff[PERIOD_W-1:0] : div_rs[PERIOD_W-1:0];
                m_reg <= (ms >= loop_x) ? MW'(ms - loop_x) : ms[MW-1:0];
            end
            OP_BEAT:
            begin
                if (mode_reg == MODE_TICK && fire_now)
                    fired_reg <= 1'b1;
                if (neg_reg && r_reg != '0)
                    r_reg <= cfg.period - r_reg;
            end
            OP_PH_STEP:
            begin
                r_reg     <= ph_ge ? ph_diff[PERIOD_W-1:0] : ph_rs[PERIOD_W-1:0];
                phase_reg <= {phase_reg[PHASE_W-2:0], ph_ge};
            end
            default: ;
        endcase
    end

    assign is_sync = (mode_reg == MODE_SYNC);
    assign beat_x  = BXW'(cur_beat_reg);

    always_comb
    begin
        res.beat_index = beat_x[BEAT_OUT_W-1:0];
        res.beat_fired = fired_reg;
        res.beat_phase = phase_reg;
    end

endmodule

// ===== sv/beat_clock_with_resync_top.sv =====
// Beat clock with server resync.
//
// Input stream (s_*): one word per item. s_tuser is the mode (tick or sync);
// s_tdata carries time_step and server_position. A tick advances the signed
// Q.16 song time and recomputes the beat; a sync snaps or eases the song time
// toward the server position. Every word produces exactly one output word on
// m_* with beat_index, beat_fired and beat_phase.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle,
// no read-back; write only while no item is in flight.
// Timing: a microcoded sequencer steps a shared restoring divider one bit per
// cycle (TIME_BITS steps for the beat count, 16 for the phase); the result is
// loaded into the output register in the done state that follows the last step.
// One item is in work at a time: s_tready is low while the sequencer runs.
// The next item is accepted while the previous result still waits on m_*.
// Stall: if the output register is still full at the last step, the sequencer
// holds there until m_tready frees it; nothing is dropped.
// Reset: song time, beat, fired-beat memory cleared; registers to defaults.
module beat_clock_with_resync_top #(
    parameter int TIME_BITS      = 40,
    parameter int MAX_LOOP_BEATS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bcr_pkg::S_TDATA_W-1:0]     s_tdata,   // time_step[23:0], server_position[63:24]
    input  logic                              s_tuser,   // mode
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bcr_pkg::M_TDATA_W-1:0]     m_tdata,   // beat_index[8:0], beat_fired[9],
                                                         // beat_phase[25:10], zero[31:26]
    // configuration
    input  logic                              cfg_we,
    input  logic [bcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bcr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bcr_pkg::*;

    localparam int LOOP_CAP = (MAX_LOOP_BEATS < 511) ? MAX_LOOP_BEATS : 511;
    localparam int LW       = $clog2(LOOP_CAP + 1);

    // configuration registers
    logic [PERIOD_W-1:0]   beat_period_reg;
    logic [LOOP_REG_W-1:0] loop_beats_reg;
    logic [BONUS_W-1:0]    bonus_window_reg;
    logic [SNAP_W-1:0]     snap_threshold_reg;
    logic [GAIN_W-1:0]     drift_gain_reg;

    // output word register
    logic                  m_tvalid_reg, m_tvalid_next;
    res_t                  res_reg;

    logic                  start, busy, hold, out_load, is_sync;
    ctl_t                  ctl;
    cfg_t                  cfg;
    logic [LW-1:0]         loop_eff;
    res_t                  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_period_reg    <= RST_BEAT_PERIOD;
            loop_beats_reg     <= RST_LOOP_BEATS;
            bonus_window_reg   <= RST_BONUS_WINDOW;
            snap_threshold_reg <= RST_SNAP_THRESHOLD;
            drift_gain_reg     <= RST_DRIFT_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BEAT_PERIOD:    beat_period_reg    <= cfg_data[PERIOD_W-1:0];
                REG_LOOP_BEATS:     loop_beats_reg     <= cfg_data[LOOP_REG_W-1:0];
                REG_BONUS_WINDOW:   bonus_window_reg   <= cfg_data[BONUS_W-1:0];
                REG_SNAP_THRESHOLD: snap_threshold_reg <= cfg_data[SNAP_W-1:0];
                REG_DRIFT_GAIN:     drift_gain_reg     <= cfg_data[GAIN_W-1:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // effective period and loop length: zero maps to one, loop clamps to cap
    always_comb
    begin
        cfg.period = (beat_period_reg == '0) ? PERIOD_W'(1) : beat_period_reg;
        cfg.bonus  = bonus_window_reg;
        cfg.snap   = snap_threshold_reg;
        cfg.gain   = drift_gain_reg;
        if (loop_beats_reg == '0)
            loop_eff = LW'(1);
        else if ({1'b0, loop_beats_reg} > 10'(LOOP_CAP))
            loop_eff = LW'(LOOP_CAP);
        else
            loop_eff = LW'(loop_beats_reg);
    end

    // handshake
    assign s_tready = ~busy;
    assign start    = s_tvalid & ~busy;
    assign hold     = m_tvalid_reg & ~m_tready;
    assign out_load = ctl.last & ~hold;

    bcr_seq #(
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .is_sync (is_sync),
        .hold    (hold),
        .busy    (busy),
        .ctl     (ctl)
    );

    bcr_dpath #(
        .TIME_BITS      (TIME_BITS),
        .MAX_LOOP_BEATS (MAX_LOOP_BEATS),
        .LOOP_CAP       (LOOP_CAP),
        .LW             (LW)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .mode            (s_tuser),
        .time_step       (s_tdata[STEP_W-1:0]),
        .server_position (s_tdata[STEP_W+SERVER_W-1:STEP_W]),
        .cfg             (cfg),
        .loop_len        (loop_eff),
        .ctl             (ctl),
        .is_sync         (is_sync),
        .res             (res)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            res_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-BEAT_OUT_W-1-PHASE_W){1'b0}},
                       res_reg.beat_phase, res_reg.beat_fired, res_reg.beat_index};

endmodule
